/* hdl/point_in_quad_winding_test_macros.svh */
// Assertion macros used by the checked module.
`ifndef POINT_IN_QUAD_WINDING_TEST_MACROS_SVH
`define POINT_IN_QUAD_WINDING_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define PQW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PQW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PQW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PQW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/pqw_pkg.sv */
package pqw_pkg;
    localparam int CoordW = 20;
    localparam int DiffW = 21;
    localparam int SumW = 18;
    localparam int AngW = 16;
    localparam int AccW = 24;
    localparam int TableLen = 24;
    localparam int CordicStepsDef = 16;
    localparam int NumVec = 4;
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        t_REG_V0X, t_REG_V0Y, t_REG_V1X, t_REG_V1Y,
        t_REG_V2X, t_REG_V2Y, t_REG_V3X, t_REG_V3Y
    } t_reg_idx;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic [AngW-1:0] t_angle;

    function automatic logic [AccW-1:0] atan_entry(input logic [4:0] i);
        logic [AccW-1:0] v;
        case (i)
            5'd0: v = 24'd2097152;  5'd1: v = 24'd1238021;
            5'd2: v = 24'd654136;   5'd3: v = 24'd332050;
            5'd4: v = 24'd166669;   5'd5: v = 24'd83416;
            5'd6: v = 24'd41718;    5'd7: v = 24'd20860;
            5'd8: v = 24'd10430;    5'd9: v = 24'd5215;
            5'd10: v = 24'd2608;    5'd11: v = 24'd1304;
            5'd12: v = 24'd652;     5'd13: v = 24'd326;
            5'd14: v = 24'd163;     5'd15: v = 24'd81;
            5'd16: v = 24'd41;      5'd17: v = 24'd20;
            5'd18: v = 24'd10;      5'd19: v = 24'd5;
            5'd20: v = 24'd3;       5'd21: v = 24'd1;
            5'd22: v = 24'd1;       default: v = 24'd0;
        endcase
        return v;
    endfunction
endpackage

/* hdl/pqw_cordic.sv */
module pqw_cordic #(
    parameter int STEPS = pqw_pkg::CordicStepsDef
) (
    input  logic i_clk,
    input  logic i_en,
    input  logic signed [pqw_pkg::DiffW-1:0] i_x,
    input  logic signed [pqw_pkg::DiffW-1:0] i_y,
    output pqw_pkg::t_angle o_angle
);
    import pqw_pkg::*;
    localparam int NS = (STEPS > TableLen) ? TableLen : STEPS;
    localparam int XW = DiffW + 3;

    logic signed [XW-1:0] r_x [NS+1];
    logic signed [XW-1:0] r_y [NS+1];
    logic [AccW-1:0] r_acc [NS+1];
    logic r_zero [NS+1];
    t_angle r_ang;
    logic [AccW-1:0] w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -XW'(i_x);
                r_y[0] <= -XW'(i_y);
                r_acc[0] <= AccW'(24'h800000);
            end else begin
                r_x[0] <= XW'(i_x);
                r_y[0] <= XW'(i_y);
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_acc[g+1] <= r_acc[g] + atan_entry(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_acc[g+1] <= r_acc[g] - atan_entry(5'(g));
                end
            end
        end
    end

    assign w_rnd = r_acc[NS] + AccW'(128);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_zero[NS] ? '0 : w_rnd[AccW-1:8];
        end
    end
    assign o_angle = r_ang;
endmodule

/* hdl/pqw_sum.sv */
module pqw_sum (
    input  logic i_clk,
    input  logic i_en,
    input  pqw_pkg::t_angle i_ang [pqw_pkg::NumVec],
    output logic o_inside,
    output logic signed [pqw_pkg::SumW-1:0] o_sum
);
    import pqw_pkg::*;
    logic signed [AngW-1:0] w_d [NumVec];
    logic signed [SumW-1:0] r_s01, r_s23, r_sum;
    logic w_in;

    for (genvar g = 0; g < NumVec; g++) begin : g_d
        assign w_d[g] = i_ang[(g + 1) % NumVec] - i_ang[g];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s01 <= SumW'(w_d[0]) + SumW'(w_d[1]);
            r_s23 <= SumW'(w_d[2]) + SumW'(w_d[3]);
            r_sum <= r_s01 + r_s23;
        end
    end
    assign w_in = (r_sum >= SumW'(32768)) || (r_sum <= -SumW'(32768));
    assign o_inside = w_in;
    assign o_sum = r_sum;
endmodule

/* hdl/point_in_quad_winding_test.sv */
// Registers in order: input, CORDIC_STEPS (max 24) rotations, angle, sums.
// Throughput: one point per cycle unless stalled; the CORDIC is fully unrolled.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and the corner registers.
module point_in_quad_winding_test #(
    parameter int CORDIC_STEPS = pqw_pkg::CordicStepsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [pqw_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [pqw_pkg::CoordW-1:0] i_cfg_data,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [pqw_pkg::CoordW-1:0] i_point_x,
    input  logic signed [pqw_pkg::CoordW-1:0] i_point_y,
    output logic o_valid,
    input  logic i_stall,
    output logic o_inside_res,
    output logic signed [pqw_pkg::SumW-1:0] o_winding_sum
);
    import pqw_pkg::*;
    `include "point_in_quad_winding_test_macros.svh"
    localparam int NS = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
    localparam int LAT = NS + 4;

    t_coord r_cx [NumVec];
    t_coord r_cy [NumVec];
    logic [LAT-1:0] r_vld;
    logic w_en;
    t_angle w_ang [NumVec];

    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumVec; k++) begin
                r_cx[k] <= '0;
                r_cy[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index[0]) r_cy[i_cfg_index[2:1]] <= i_cfg_data;
            else r_cx[i_cfg_index[2:1]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LAT-1];

    for (genvar g = 0; g < NumVec; g++) begin : g_c
        pqw_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(DiffW'(r_cx[g]) - DiffW'(i_point_x)),
            .i_y(DiffW'(r_cy[g]) - DiffW'(i_point_y)),
            .o_angle(w_ang[g])
        );
    end

    pqw_sum u_sum (
        .i_clk(i_clk), .i_en(w_en), .i_ang(w_ang),
        .o_inside(o_inside_res), .o_sum(o_winding_sum)
    );

    `PQW_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `PQW_ASSERT_IMPL(a_in_flag, i_clk, i_rst_n, o_valid,
        o_inside_res == ((o_winding_sum >= 18'sd32768) || (o_winding_sum <= -18'sd32768)))
    `PQW_ASSERT_IMPL(a_stall, i_clk, i_rst_n, o_stall, o_valid && i_stall)
endmodule

/* tb/tb_point_in_quad_winding_test.sv */
module tb_point_in_quad_winding_test;
    import pqw_pkg::*;

    localparam int Steps = CordicStepsDef;
    localparam int Latency = Steps + 4;
    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CoordW-1:0] i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic signed [CoordW-1:0] i_point_x;
    logic signed [CoordW-1:0] i_point_y;
    logic o_valid;
    logic i_stall;
    logic o_inside_res;
    logic signed [SumW-1:0] o_winding_sum;

    point_in_quad_winding_test #(.CORDIC_STEPS(Steps)) uut (.*);

    // Arctangent table of 2^24 units per turn, rounded to nearest.
    function automatic longint arctan_step(input int i);
        longint tbl [24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
            20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[i];
    endfunction

    function automatic logic [AngW-1:0] direction_of(input longint x, input longint y);
        longint acc;
        longint xs;
        longint ys;
        int n;
        acc = 0;
        n = (Steps > 24) ? 24 : Steps;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 64'sh800000;
        end
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc += arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                acc -= arctan_step(i);
            end
        end
        return AngW'((acc + 128) >>> 8);
    endfunction

    typedef struct packed {
        logic in_flag;
        logic signed [SumW-1:0] sum;
    } winding_t;

    class winding_board;
        logic signed [CoordW-1:0] corner [8];
        winding_t pending [$];
        int errors;

        function void note_point(input logic signed [CoordW-1:0] px,
                                 input logic signed [CoordW-1:0] py);
            longint total;
            longint ax, ay, bx, by;
            logic [AngW-1:0] d;
            int b;
            winding_t w;
            total = 0;
            for (int e = 0; e < 4; e++) begin
                b = (e + 1) % 4;
                ax = longint'(corner[2*e]) - px;
                ay = longint'(corner[2*e+1]) - py;
                bx = longint'(corner[2*b]) - px;
                by = longint'(corner[2*b+1]) - py;
                d = direction_of(bx, by) - direction_of(ax, ay);
                total += longint'($signed(d));
            end
            w.in_flag = (total >= 32768 || total <= -32768);
            w.sum = SumW'(total);
            pending.push_back(w);
        endfunction

        function void check_result(input logic flag, input logic signed [SumW-1:0] sum);
            winding_t w;
            if (pending.size() == 0) begin
                $error("unexpected result inside_res=%0d winding_sum=%0d", flag, sum);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (flag !== w.in_flag) begin
                $error("inside_res expected %0d actual %0d", w.in_flag, flag);
                errors++;
            end
            if (sum !== w.sum) begin
                $error("winding_sum expected %0d actual %0d", w.sum, sum);
                errors++;
            end
        endfunction
    endclass

    winding_board board;
    int cycles;
    int idle_pct_in;
    int idle_pct_out;
    int hold_off;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_point_in_quad_winding_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_inside_res, o_winding_sum);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct_out);
        end
    end

    task automatic write_corner(input t_reg_idx idx, input logic signed [CoordW-1:0] v);
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.corner[idx] = v;
    endtask

    task automatic send_point(input logic signed [CoordW-1:0] px,
                              input logic signed [CoordW-1:0] py);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct_in) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        do @(posedge i_clk); while (o_stall);
        board.note_point(px, py);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord(input int mode);
        case (mode)
            0: return CoordW'($urandom);
            1: return CoordW'($signed($urandom_range(4000)) - 2000);
            default: return CoordW'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic set_quad(input int mode);
        for (int r = 0; r < 8; r++)
            write_corner(t_reg_idx'(r), rand_coord(mode));
    endtask

    initial begin
        logic signed [CoordW-1:0] mx, mn;
        board = new();
        cycles = 0;
        hold_off = 0;
        idle_pct_in = 32;
        idle_pct_out = 32;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 0;
        i_point_x = '0;
        i_point_y = '0;
        i_stall = 0;
        for (int r = 0; r < 8; r++) board.corner[r] = '0;
        mx = {1'b0, {(CoordW-1){1'b1}}};
        mn = {1'b1, {(CoordW-1){1'b0}}};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All corners at zero first, then a square of side 320 centred on the origin and the extreme corners.
        send_point('0, '0);
        send_point(16, 16);
        drain();
        write_corner(t_REG_V0X, -160); write_corner(t_REG_V0Y, -160);
        write_corner(t_REG_V1X, 160);  write_corner(t_REG_V1Y, -160);
        write_corner(t_REG_V2X, 160);  write_corner(t_REG_V2Y, 160);
        write_corner(t_REG_V3X, -160); write_corner(t_REG_V3Y, 160);
        send_point(0, 0);
        send_point(-160, -160);
        send_point(160, 0);
        send_point(0, -160);
        send_point(1000, 5);
        send_point(mx, mx);
        send_point(mn, mn);
        send_point(mx, mn);
        drain();
        write_corner(t_REG_V0X, mn); write_corner(t_REG_V0Y, mn);
        write_corner(t_REG_V1X, mx); write_corner(t_REG_V1Y, mn);
        write_corner(t_REG_V2X, mx); write_corner(t_REG_V2Y, mx);
        write_corner(t_REG_V3X, mn); write_corner(t_REG_V3Y, mx);
        send_point(0, 0);
        send_point(mn, mn);
        send_point(mx, mx);
        send_point(mn, mx);
        send_point(0, mx);
        send_point(-1, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_quad(ph % 3);
            if (ph == 3) begin
                idle_pct_in = 0;
                idle_pct_out = 0;
            end else begin
                idle_pct_in = 32;
                idle_pct_out = 32;
            end
            if (ph == 5) hold_off = 200;
            for (int k = 0; k < 80; k++) begin
                if ($urandom_range(9) == 0)
                    send_point(board.corner[2*$urandom_range(3)],
                               board.corner[2*$urandom_range(3)+1]);
                else
                    send_point(rand_coord(ph % 3), rand_coord(ph % 3));
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_point_in_quad_winding_test OK");
        else
            $display("tb_point_in_quad_winding_test NOT OK");
        $finish;
    end
endmodule
